// ===== rtl/core/fgc_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT32 geometry calculator package
// Shared constants, controller states and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fgc_pkg;

  localparam logic [31:0] RESERVED_SECTORS = 32'd32;
  localparam logic [31:0] MIN_CLUSTERS     = 32'd65527;
  localparam logic [7:0]  FIRST_AUTO_SIZE  = 8'd64;
  localparam logic [7:0]  LAST_AUTO_SIZE   = 8'd4;
  localparam logic [32:0] FAT_ROUND_ADD    = 33'd129;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_WAIT_N,
    S_CHK_N,
    S_WAIT_FC,
    S_CHK_D,
    S_NEXT,
    S_DONE,
    S_FAIL
  } fgc_state_t;

  typedef struct packed {
    logic load;
    logic div_n;
    logic div_fc;
    logic store_n;
    logic store_d;
    logic next_cand;
    logic write_ok;
    logic write_bad;
  } fgc_cmd_t;

  typedef struct packed {
    logic size_zero;
    logic n_small;
    logic d_bad;
    logic last_cand;
    logic div_done;
    logic out_free;
  } fgc_stat_t;

endpackage

// ===== rtl/core/fgc_if.sv =====
// ----------------------------------------------------------------------------
// FAT32 geometry calculator channels
// Valid/ready channels for the volume request item and the geometry result.
// ----------------------------------------------------------------------------
interface fgc_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] size_mb;
  logic [7:0]  cluster_request;

  modport source (output valid, output size_mb, output cluster_request, input ready);
  modport sink (input valid, input size_mb, input cluster_request, output ready);
endinterface

interface fgc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_sectors;
  logic [25:0] fat_sectors;
  logic [7:0]  cluster_sectors;
  logic [31:0] data_clusters;
  logic        status;

  modport source (
    output valid, output total_sectors, output fat_sectors, output cluster_sectors,
    output data_clusters, output status, input ready
  );
  modport sink (
    input valid, input total_sectors, input fat_sectors, input cluster_sectors,
    input data_clusters, input status, output ready
  );
endinterface

// ===== rtl/core/fat32_geometry_calculator_core.sv =====
// ----------------------------------------------------------------------------
// FAT32 geometry calculator core
// Works out total sectors, sectors per cluster, data clusters and sectors
// per FAT for a volume given in megabytes.
// ----------------------------------------------------------------------------
// One request item gives one result item. Each cluster size tried costs up to
// two 32-step divisions in the shared one-bit-per-cycle divider; the second is
// skipped when the first gives too few clusters. An explicit cluster size is
// tried alone, and the automatic search tries up to five sizes. A volume of
// zero megabytes is rejected without any division. Items are handled one at a
// time; a new item is taken while the previous result still waits in the
// output register.
module fat32_geometry_calculator_core
  import fgc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fgc_in_if.sink    in_chan,
  fgc_out_if.source out_chan
);

  fgc_cmd_t  cmd;
  fgc_stat_t stat;

  fgc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fgc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // A request item is never followed by another in the very next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("second item accepted while the first is in progress");

  // A good result always carries a usable cluster count and size.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.status |->
      (out_chan.data_clusters >= MIN_CLUSTERS) && (out_chan.cluster_sectors != 8'd0))
    else $error("good result below the minimum cluster count");

  // A bad-format result carries all-zero geometry.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status |->
      (out_chan.total_sectors == 32'd0) && (out_chan.fat_sectors == 26'd0) &&
      (out_chan.cluster_sectors == 8'd0) && (out_chan.data_clusters == 32'd0))
    else $error("bad-format result with nonzero fields");

endmodule

// ===== rtl/core/fgc_div.sv =====
// ----------------------------------------------------------------------------
// FAT32 geometry calculator divider
// Radix-2 restoring divider, 32-bit dividend by 8-bit nonzero divisor,
// one quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module fgc_div
  import fgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] quo_r, quo_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [8:0]  trial;
  logic [8:0]  diff;
  logic        fits;

  assign trial = {rem_r, quo_r[31]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = 8'd0;
      cnt_nxt  = 5'd31;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], fits};
      rem_nxt = fits ? diff[7:0] : trial[7:0];
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/fgc_datapath.sv =====
// ----------------------------------------------------------------------------
// FAT32 geometry calculator datapath
// Holds the request, the candidate cluster size and the intermediate counts,
// drives the shared divider and owns the result register.
// ----------------------------------------------------------------------------
module fgc_datapath
  import fgc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  fgc_cmd_t  cmd,
  output fgc_stat_t stat,
  fgc_in_if.sink    in_chan,
  fgc_out_if.source out_chan
);

  logic [31:0] total_r;
  logic [7:0]  cand_r;
  logic        auto_r;
  logic [31:0] n_r;
  logic [31:0] d_r;
  logic        fc_over_r;

  logic        out_valid_r;
  logic [31:0] out_total_r;
  logic [25:0] out_fat_r;
  logic [7:0]  out_csize_r;
  logic [31:0] out_data_r;
  logic        out_status_r;

  logic        div_start;
  logic [31:0] div_dividend;
  logic        div_done;
  logic [31:0] div_quot;
  logic [32:0] n_plus;
  logic [32:0] fat_sum;

  assign n_plus  = {1'b0, n_r} + 33'd1;
  assign fat_sum = {1'b0, d_r} + FAT_ROUND_ADD;

  assign div_start    = cmd.div_n | cmd.div_fc;
  assign div_dividend = cmd.div_fc ? {5'd0, n_plus[32:6]} : (total_r - RESERVED_SECTORS);

  fgc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cand_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      total_r <= {in_chan.size_mb, 11'd0};
      auto_r  <= (in_chan.cluster_request == 8'd0);
      cand_r  <= (in_chan.cluster_request == 8'd0) ? FIRST_AUTO_SIZE : in_chan.cluster_request;
    end else if (cmd.next_cand) begin
      cand_r <= {1'b0, cand_r[7:1]};
    end
    if (cmd.store_n) begin
      n_r <= div_quot;
    end
    if (cmd.store_d) begin
      d_r       <= n_r - div_quot - 32'd1;
      fc_over_r <= (div_quot >= n_r);
    end
    if (cmd.write_ok) begin
      out_total_r  <= total_r;
      out_fat_r    <= fat_sum[32:7];
      out_csize_r  <= cand_r;
      out_data_r   <= d_r;
      out_status_r <= 1'b0;
    end else if (cmd.write_bad) begin
      out_total_r  <= 32'd0;
      out_fat_r    <= 26'd0;
      out_csize_r  <= 8'd0;
      out_data_r   <= 32'd0;
      out_status_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.write_ok || cmd.write_bad) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.size_zero = (total_r == 32'd0);
  assign stat.n_small   = (n_r < MIN_CLUSTERS);
  assign stat.d_bad     = fc_over_r || (d_r < MIN_CLUSTERS);
  assign stat.last_cand = !auto_r || (cand_r == LAST_AUTO_SIZE);
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid_r || out_chan.ready;

  assign out_chan.valid           = out_valid_r;
  assign out_chan.total_sectors   = out_total_r;
  assign out_chan.fat_sectors     = out_fat_r;
  assign out_chan.cluster_sectors = out_csize_r;
  assign out_chan.data_clusters   = out_data_r;
  assign out_chan.status          = out_status_r;

endmodule

// ===== rtl/core/fgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// FAT32 geometry calculator controller
// Sequences up to two divisions for each candidate cluster size, the checks
// against the minimum cluster count and the write of the result.
// ----------------------------------------------------------------------------
module fgc_ctrl
  import fgc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fgc_stat_t stat,
  output fgc_cmd_t  cmd
);

  fgc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        state_nxt = stat.size_zero ? S_FAIL : S_WAIT_N;
      end
      S_WAIT_N: begin
        if (stat.div_done) state_nxt = S_CHK_N;
      end
      S_CHK_N: begin
        state_nxt = stat.n_small ? S_NEXT : S_WAIT_FC;
      end
      S_WAIT_FC: begin
        if (stat.div_done) state_nxt = S_CHK_D;
      end
      S_CHK_D: begin
        state_nxt = stat.d_bad ? S_NEXT : S_DONE;
      end
      S_NEXT: begin
        state_nxt = stat.last_cand ? S_FAIL : S_START;
      end
      S_DONE, S_FAIL: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_START:   cmd.div_n     = !stat.size_zero;
      S_WAIT_N:  cmd.store_n   = stat.div_done;
      S_CHK_N:   cmd.div_fc    = !stat.n_small;
      S_WAIT_FC: cmd.store_d   = stat.div_done;
      S_CHK_D:   cmd.next_cand = 1'b0;
      S_NEXT:    cmd.next_cand = !stat.last_cand;
      S_DONE:    cmd.write_ok  = stat.out_free;
      S_FAIL:    cmd.write_bad = stat.out_free;
      default:   cmd           = '0;
    endcase
  end

endmodule
